// File: rtl/core/wsu_pkg.sv
// Shared types and constants of the WebSocket frame unmasker.
package wsu_pkg;

  localparam logic [3:0] OPC_CLOSE   = 4'h8;
  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_EXT64   = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_TRAIL   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_CLOSE   = 2'd1,
    KIND_TRUNC   = 2'd2
  } kind_e;

  // One queue entry holds every result caused by one accepted byte.
  typedef struct packed {
    logic [3:0] opcode;
    kind_e      first_kind;
    logic [7:0] first_data;
    logic       first_done;
    logic       has_second;
    kind_e      second_kind;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [3:0] opcode;
    logic       done;
    logic       last;
  } result_t;

endpackage

// File: rtl/core/wsu_parser.sv
// Front end: parses the frame header, unmasks payload bytes and builds queue entries.
module wsu_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       data_i,
  input  logic             end_i,
  output logic             push_o,
  output wsu_pkg::entry_t  entry_o
);

  wsu_pkg::phase_e phase_q, phase_d;
  logic [3:0]  hdr_cnt_q, hdr_cnt_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        mask_q, mask_d;
  logic        ext64_q, ext64_d;
  logic [63:0] length_q, length_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  idx_q, idx_d;

  logic [6:0]  len_code;
  logic [63:0] ext_len;
  logic [3:0]  cnt_inc;
  logic [3:0]  ext_need;
  logic        ext_done;
  logic        key_done;
  logic        pay_last;
  logic        complete;
  logic        has_pay;
  logic        close_req;
  logic        trunc;
  logic [7:0]  key_byte;

  assign len_code = data_i[6:0];
  assign ext_len  = {length_q[55:0], data_i};
  assign cnt_inc  = hdr_cnt_q + 4'd1;
  assign ext_need = ext64_q ? wsu_pkg::EXT64_BYTES : wsu_pkg::EXT16_BYTES;
  assign ext_done = (cnt_inc >= ext_need);
  assign key_done = (cnt_inc >= wsu_pkg::KEY_BYTES);
  // The remaining count reaches one on the final payload byte.
  assign pay_last = (length_q == 64'd1);

  // Next phase, and whether the frame completes on this byte.
  always_comb begin
    phase_d  = phase_q;
    complete = 1'b0;
    if (accept_i) begin
      unique case (phase_q)
        wsu_pkg::PH_FIRST: begin
          if (!end_i) phase_d = wsu_pkg::PH_SECOND;
        end
        wsu_pkg::PH_SECOND: begin
          if (len_code < wsu_pkg::LEN_EXT16) begin
            if (data_i[7]) phase_d = wsu_pkg::PH_KEY;
            else if (len_code == 7'd0) complete = 1'b1;
            else phase_d = wsu_pkg::PH_PAYLOAD;
          end else begin
            phase_d = wsu_pkg::PH_EXTLEN;
          end
        end
        wsu_pkg::PH_EXTLEN: begin
          if (ext_done) begin
            if (mask_q) phase_d = wsu_pkg::PH_KEY;
            else if (ext_len == 64'd0) complete = 1'b1;
            else phase_d = wsu_pkg::PH_PAYLOAD;
          end
        end
        wsu_pkg::PH_KEY: begin
          if (key_done) begin
            if (length_q == 64'd0) complete = 1'b1;
            else phase_d = wsu_pkg::PH_PAYLOAD;
          end
        end
        wsu_pkg::PH_PAYLOAD: begin
          if (pay_last) complete = 1'b1;
        end
        default: ;
      endcase
      if (complete) phase_d = wsu_pkg::PH_TRAIL;
      // A truncation is reported when the buffer ends inside an unfinished frame.
      trunc = end_i && (phase_d == wsu_pkg::PH_SECOND || phase_d == wsu_pkg::PH_EXTLEN ||
                        phase_d == wsu_pkg::PH_KEY || phase_d == wsu_pkg::PH_PAYLOAD);
      if (end_i) phase_d = wsu_pkg::PH_FIRST;
    end else begin
      trunc = 1'b0;
    end
  end

  always_comb begin
    case (idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // Datapath updates and the queue entry.
  always_comb begin
    hdr_cnt_d = hdr_cnt_q;
    opcode_d  = opcode_q;
    mask_d    = mask_q;
    ext64_d   = ext64_q;
    length_d  = length_q;
    key_d     = key_q;
    idx_d     = idx_q;
    has_pay   = 1'b0;
    entry_o   = '0;
    if (accept_i) begin
      unique case (phase_q)
        wsu_pkg::PH_FIRST: begin
          opcode_d  = data_i[3:0];
          mask_d    = 1'b0;
          ext64_d   = 1'b0;
          length_d  = '0;
          key_d     = '0;
          idx_d     = '0;
          hdr_cnt_d = '0;
        end
        wsu_pkg::PH_SECOND: begin
          mask_d    = data_i[7];
          hdr_cnt_d = '0;
          idx_d     = '0;
          ext64_d   = (len_code == wsu_pkg::LEN_EXT64);
          length_d  = (len_code < wsu_pkg::LEN_EXT16) ? 64'(len_code) : 64'd0;
        end
        wsu_pkg::PH_EXTLEN: begin
          length_d  = ext_len;
          hdr_cnt_d = ext_done ? 4'd0 : cnt_inc;
          idx_d     = '0;
        end
        wsu_pkg::PH_KEY: begin
          key_d     = {key_q[23:0], data_i};
          hdr_cnt_d = key_done ? 4'd0 : cnt_inc;
          idx_d     = '0;
        end
        wsu_pkg::PH_PAYLOAD: begin
          has_pay  = 1'b1;
          idx_d    = idx_q + 2'd1;
          length_d = length_q - 64'd1;
        end
        default: ;
      endcase
    end
    close_req = complete && mask_d && (opcode_q == wsu_pkg::OPC_CLOSE);

    entry_o.opcode = opcode_q;
    if (has_pay) begin
      entry_o.first_kind  = wsu_pkg::KIND_PAYLOAD;
      entry_o.first_data  = data_i ^ (mask_q ? key_byte : 8'd0);
      entry_o.first_done  = pay_last;
      entry_o.has_second  = close_req || trunc;
      entry_o.second_kind = close_req ? wsu_pkg::KIND_CLOSE : wsu_pkg::KIND_TRUNC;
    end else begin
      entry_o.first_kind  = close_req ? wsu_pkg::KIND_CLOSE : wsu_pkg::KIND_TRUNC;
      entry_o.first_data  = 8'd0;
      entry_o.first_done  = 1'b0;
      entry_o.has_second  = 1'b0;
      entry_o.second_kind = wsu_pkg::KIND_TRUNC;
    end
  end

  assign push_o = has_pay || close_req || trunc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= wsu_pkg::PH_FIRST;
      hdr_cnt_q <= '0;
      opcode_q  <= '0;
      mask_q    <= 1'b0;
      ext64_q   <= 1'b0;
      length_q  <= '0;
      key_q     <= '0;
      idx_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      opcode_q  <= opcode_d;
      mask_q    <= mask_d;
      ext64_q   <= ext64_d;
      length_q  <= length_d;
      key_q     <= key_d;
      idx_q     <= idx_d;
    end
  end

endmodule

// File: rtl/core/wsu_queue.sv
// Short entry queue between the parser and the result emitter.
module wsu_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  wsu_pkg::entry_t        push_data_i,
  input  logic                   pop_i,
  output wsu_pkg::entry_t        pop_data_o,
  output wsu_pkg::queue_status_t status_o
);

  localparam int unsigned AW = wsu_pkg::QUEUE_AW;
  localparam logic [AW-1:0] LAST_PTR = AW'(wsu_pkg::QUEUE_DEPTH - 1);
  localparam logic [AW:0]   FULL_CNT = (AW + 1)'(wsu_pkg::QUEUE_DEPTH);

  wsu_pkg::entry_t mem_q [wsu_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AW:0]   count_q, count_d;
  logic          do_push, do_pop;

  assign status_o.full  = (count_q == FULL_CNT);
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    else if (do_pop && !do_push) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// File: rtl/core/wsu_emitter.sv
// Back end: expands queue entries into one or two results behind an output register.
module wsu_emitter (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wsu_pkg::entry_t        entry_i,
  input  wsu_pkg::queue_status_t status_i,
  output logic                   pop_o,
  output logic                   valid_o,
  input  logic                   ready_i,
  output wsu_pkg::result_t       result_o
);

  logic             valid_q, valid_d;
  logic             pend_q, pend_d;
  wsu_pkg::kind_e   sec_kind_q, sec_kind_d;
  logic [3:0]       sec_op_q, sec_op_d;
  wsu_pkg::result_t res_q, res_d;
  logic             out_free;

  assign out_free = !valid_q || ready_i;
  assign pop_o    = out_free && !pend_q && !status_i.empty;

  always_comb begin
    valid_d    = valid_q;
    pend_d     = pend_q;
    sec_kind_d = sec_kind_q;
    sec_op_d   = sec_op_q;
    res_d      = res_q;
    if (out_free) begin
      if (pend_q) begin
        // The second result of an entry always closes its run.
        res_d.kind   = sec_kind_q;
        res_d.data   = 8'd0;
        res_d.opcode = sec_op_q;
        res_d.done   = 1'b0;
        res_d.last   = 1'b1;
        valid_d      = 1'b1;
        pend_d       = 1'b0;
      end else if (!status_i.empty) begin
        res_d.kind   = entry_i.first_kind;
        res_d.data   = entry_i.first_data;
        res_d.opcode = entry_i.opcode;
        res_d.done   = entry_i.first_done;
        res_d.last   = !entry_i.has_second;
        valid_d      = 1'b1;
        pend_d       = entry_i.has_second;
        sec_kind_d   = entry_i.second_kind;
        sec_op_d     = entry_i.opcode;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    sec_kind_q <= sec_kind_d;
    sec_op_q   <= sec_op_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

// File: rtl/core/websocket_frame_unmasker.sv
// Top level of the WebSocket frame unmasker.
//
// Receives a WebSocket buffer one byte per transaction (tlast on the buffer's last
// byte), parses the frame header and emits each payload byte unmasked, a close-reply
// request after a complete masked close frame, and a truncation result when the buffer
// ends inside a frame. The input takes one byte every cycle unless the queue is full; a
// byte that causes two results (a payload byte followed by a close request or a
// truncation) holds the single output register for both, and a four-entry queue between
// the header parser and the output stage absorbs that and downstream stalls. The first
// result of a byte is queued, then registered at the output. A header byte produces
// a result only when it completes a masked close frame or ends the buffer inside the
// frame. Results leave in order, with tlast on the last result caused by each input byte.
module websocket_frame_unmasker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // buffer_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] payload_data, [11:8] frame_opcode, zeros
  output logic [2:0]  m_axis_tuser_o,   // [1:0] kind, [2] payload_done
  output logic        m_axis_tlast_o    // run_last
);

  wsu_pkg::entry_t        push_entry;
  wsu_pkg::entry_t        pop_entry;
  wsu_pkg::queue_status_t q_status;
  wsu_pkg::result_t       result;
  logic                   accept;
  logic                   push;
  logic                   pop;

  assign s_axis_tready_o = !q_status.full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  wsu_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .data_i   (s_axis_tdata_i),
    .end_i    (s_axis_tlast_i),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  wsu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .pop_data_o  (pop_entry),
    .status_o    (q_status)
  );

  wsu_emitter u_emitter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .entry_i  (pop_entry),
    .status_i (q_status),
    .pop_o    (pop),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (result)
  );

  assign m_axis_tdata_o = {4'd0, result.opcode, result.data};
  assign m_axis_tuser_o = {result.done, result.kind};
  assign m_axis_tlast_o = result.last;

endmodule

// File: bench/tb_websocket_frame_unmasker.sv
// Self-checking testbench for the WebSocket frame unmasker: directed frames, then random buffers.
module tb_websocket_frame_unmasker;
  timeunit 1ns;
  timeprecision 1ps;

  import wsu_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_BYTES = 450;

  typedef enum logic [1:0] {
    ROW_MODEL = 2'd0,
    ROW_QUIET = 2'd1,
    ROW_ONE   = 2'd2
  } row_check_e;

  typedef struct packed {
    logic [7:0] data;
    logic       eob;
    row_check_e check;
    result_t    res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  websocket_frame_unmasker dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Parser state of the predictor.
  phase_e      rx_phase = PH_FIRST;
  logic [3:0]  hdr_count = '0;
  logic [3:0]  frame_opc = '0;
  logic        frame_masked = 1'b0;
  logic [6:0]  len_code = '0;
  logic [63:0] pay_len = '0;
  logic [31:0] mask_key = '0;
  logic [63:0] pay_index = '0;

  result_t     byte_results[$];
  result_t     deframed_q[$];
  logic        step_ignored;
  dir_row_t    dir_rows[$];
  logic [8:0]  frame_bytes[$];
  int          mismatch_count = 0;
  int          parsed_bytes = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int          rcv_cycle = 0;
  int          rcv_mode = 0;
  int          rcv_hold = 0;
  logic        rcv_level = 1'b1;
  result_t     want;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic result_t make_result(kind_e k, logic [7:0] d, logic [3:0] o, logic dn,
                                          logic lst);
    result_t r;
    r.kind   = k;
    r.data   = d;
    r.opcode = o;
    r.done   = dn;
    r.last   = lst;
    return r;
  endfunction

  function automatic logic open_payload();
    pay_index = '0;
    hdr_count = '0;
    if (pay_len == 64'd0) return 1'b1;
    rx_phase = PH_PAYLOAD;
    return 1'b0;
  endfunction

  function automatic logic length_settled();
    hdr_count = '0;
    if (frame_masked) begin
      rx_phase = PH_KEY;
      return 1'b0;
    end
    return open_payload();
  endfunction

  // Advances the parser by one received byte and leaves its results in byte_results.
  task automatic deframe_byte(input logic [7:0] d, input logic eob);
    logic       finished;
    logic       last_byte;
    logic [7:0] plain;
    result_t    r;
    finished = 1'b0;
    byte_results.delete();
    step_ignored = (rx_phase == PH_TRAIL);
    case (rx_phase)
      PH_FIRST: begin
        frame_opc    = d[3:0];
        frame_masked = 1'b0;
        len_code     = '0;
        pay_len      = '0;
        mask_key     = '0;
        pay_index    = '0;
        hdr_count    = '0;
        if (!eob) rx_phase = PH_SECOND;
      end
      PH_SECOND: begin
        frame_masked = d[7];
        len_code     = d[6:0];
        hdr_count    = '0;
        if (len_code < LEN_EXT16) begin
          pay_len  = 64'(len_code);
          finished = length_settled();
        end else begin
          pay_len  = '0;
          rx_phase = PH_EXTLEN;
        end
      end
      PH_EXTLEN: begin
        pay_len   = {pay_len[55:0], d};
        hdr_count = hdr_count + 4'd1;
        if (hdr_count >= ((len_code == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES))
          finished = length_settled();
      end
      PH_KEY: begin
        mask_key  = {mask_key[23:0], d};
        hdr_count = hdr_count + 4'd1;
        if (hdr_count >= KEY_BYTES) finished = open_payload();
      end
      PH_PAYLOAD: begin
        // Key bytes are applied most significant first, cycling every four bytes.
        plain = d;
        if (frame_masked) plain = d ^ 8'(mask_key >> (8 * (3 - int'(pay_index[1:0]))));
        pay_index = pay_index + 64'd1;
        last_byte = (pay_index == pay_len);
        byte_results.push_back(make_result(KIND_PAYLOAD, plain, frame_opc, last_byte, 1'b0));
        if (last_byte) finished = 1'b1;
      end
      default: ;
    endcase
    if (finished) begin
      rx_phase = PH_TRAIL;
      if (frame_masked && frame_opc == OPC_CLOSE)
        byte_results.push_back(make_result(KIND_CLOSE, 8'h00, frame_opc, 1'b0, 1'b0));
    end
    if (eob) begin
      if (rx_phase >= PH_SECOND && rx_phase <= PH_PAYLOAD)
        byte_results.push_back(make_result(KIND_TRUNC, 8'h00, frame_opc, 1'b0, 1'b0));
      rx_phase = PH_FIRST;
    end
    if (byte_results.size() > 0) begin
      r = byte_results[byte_results.size() - 1];
      r.last = 1'b1;
      byte_results[byte_results.size() - 1] = r;
    end
  endtask

  // Presents one byte, with bursts and random gaps, and returns once it is accepted.
  task automatic send_byte(input logic [7:0] d, input logic eob);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= d;
    s_axis_tlast_i  <= eob;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (deframed_q.size() != 0);
  endtask

  task automatic add_row(input logic [7:0] d, input logic eob, input row_check_e c,
                         input result_t r);
    dir_row_t row;
    row.data  = d;
    row.eob   = eob;
    row.check = c;
    row.res   = r;
    dir_rows.push_back(row);
  endtask

  // Builds one random buffer: mostly well-formed frames, some cut short, some pure noise.
  task automatic build_frame();
    int          sel;
    int          r;
    int          plen;
    int          enc;
    int          cut;
    logic [3:0]  opc_v;
    logic        masked_v;
    logic        huge;
    logic [63:0] len64;
    logic [7:0]  pb;
    logic [8:0]  tail;
    frame_bytes.delete();
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      repeat ($urandom_range(1, 4)) frame_bytes.push_back({1'b0, 8'($urandom)});
    end else begin
      // A huge declared length with a few payload bytes always ends as a truncation.
      huge     = (sel >= 96);
      opc_v    = ($urandom_range(0, 2) == 0) ? OPC_CLOSE : 4'($urandom);
      masked_v = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 10) plen = 0;
      else if (r < 85) plen = $urandom_range(1, 12);
      else if (r < 95) plen = $urandom_range(13, 40);
      else plen = $urandom_range(100, 300);
      if (huge) plen = $urandom_range(0, 6);
      if (huge) enc = 2;
      else if (plen >= 126) enc = $urandom_range(1, 2);
      else begin
        r = $urandom_range(0, 9);
        enc = (r < 7) ? 0 : (r < 9) ? 1 : 2;
      end
      len64 = huge ? {8'($urandom_range(1, 255)), 24'($urandom), 32'($urandom)} : 64'(plen);
      frame_bytes.push_back({1'b0, 4'($urandom), opc_v});
      frame_bytes.push_back({1'b0, masked_v,
                             (enc == 0) ? 7'(plen) : (enc == 1) ? LEN_EXT16 : LEN_EXT64});
      if (enc == 1) begin
        frame_bytes.push_back({1'b0, len64[15:8]});
        frame_bytes.push_back({1'b0, len64[7:0]});
      end else if (enc == 2) begin
        for (int i = 7; i >= 0; i--) frame_bytes.push_back({1'b0, 8'(len64 >> (8 * i))});
      end
      if (masked_v) repeat (4) frame_bytes.push_back({1'b0, 8'($urandom)});
      for (int i = 0; i < plen; i++) begin
        r = $urandom_range(0, 9);
        pb = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
        frame_bytes.push_back({1'b0, pb});
      end
      if (!huge) begin
        if ($urandom_range(0, 9) < 3)
          repeat ($urandom_range(1, 3)) frame_bytes.push_back({1'b0, 8'($urandom)});
        if ($urandom_range(0, 99) < 15 && frame_bytes.size() > 2) begin
          cut = $urandom_range(1, frame_bytes.size() - 2);
          while (frame_bytes.size() > cut + 1) void'(frame_bytes.pop_back());
        end
      end
    end
    tail = frame_bytes.pop_back();
    tail[8] = 1'b1;
    frame_bytes.push_back(tail);
  endtask

  initial begin
    dir_row_t   row;
    logic [8:0] fb;

    add_row(8'h81, 1'b1, ROW_QUIET, '0);
    add_row(8'h82, 1'b0, ROW_QUIET, '0);
    add_row(8'h00, 1'b0, ROW_QUIET, '0);
    add_row(8'hFF, 1'b1, ROW_QUIET, '0);
    add_row(8'h88, 1'b0, ROW_QUIET, '0);
    add_row(8'h80, 1'b0, ROW_QUIET, '0);
    add_row(8'h00, 1'b0, ROW_QUIET, '0);
    add_row(8'h00, 1'b0, ROW_QUIET, '0);
    add_row(8'h00, 1'b0, ROW_QUIET, '0);
    add_row(8'hFF, 1'b1, ROW_ONE, make_result(KIND_CLOSE, 8'h00, OPC_CLOSE, 1'b0, 1'b1));
    // Opcode 1, 2-byte extended length of one, key FF 00 A5 5A, one payload byte.
    add_row(8'h81, 1'b0, ROW_QUIET, '0);
    add_row(8'hFE, 1'b0, ROW_QUIET, '0);
    add_row(8'h00, 1'b0, ROW_QUIET, '0);
    add_row(8'h01, 1'b0, ROW_QUIET, '0);
    add_row(8'hFF, 1'b0, ROW_QUIET, '0);
    add_row(8'h00, 1'b0, ROW_QUIET, '0);
    add_row(8'hA5, 1'b0, ROW_QUIET, '0);
    add_row(8'h5A, 1'b0, ROW_QUIET, '0);
    add_row(8'hFF, 1'b1, ROW_MODEL, '0);
    add_row(8'h89, 1'b0, ROW_QUIET, '0);
    add_row(8'h85, 1'b0, ROW_QUIET, '0);
    add_row(8'h12, 1'b1, ROW_ONE, make_result(KIND_TRUNC, 8'h00, 4'h9, 1'b0, 1'b1));
    add_row(8'h08, 1'b0, ROW_QUIET, '0);
    add_row(8'h01, 1'b0, ROW_QUIET, '0);
    add_row(8'h7E, 1'b1, ROW_MODEL, '0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_byte(row.data, row.eob);
      deframe_byte(row.data, row.eob);
      case (row.check)
        ROW_MODEL: foreach (byte_results[j]) deframed_q.push_back(byte_results[j]);
        ROW_ONE:   deframed_q.push_back(row.res);
        default: ;
      endcase
    end
    drain_results();

    while (parsed_bytes < RANDOM_BYTES) begin
      build_frame();
      foreach (frame_bytes[i]) begin
        fb = frame_bytes[i];
        send_byte(fb[7:0], fb[8]);
        deframe_byte(fb[7:0], fb[8]);
        foreach (byte_results[j]) deframed_q.push_back(byte_results[j]);
        if (!step_ignored) parsed_bytes++;
      end
      if ($urandom_range(0, 19) == 0) drain_results();
    end

    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (deframed_q.size() != 0);
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver stall pattern: switches between free flow, random, periodic, and long runs
  // of stalls.
  always @(posedge clk_i) begin
    rcv_cycle++;
    if (rcv_cycle % 128 == 0) rcv_mode = $urandom_range(0, 3);
    case (rcv_mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready_i <= ((rcv_cycle % 5) < 3);
      default: begin
        if (rcv_hold == 0) begin
          rcv_level = ~rcv_level;
          rcv_hold  = $urandom_range(1, 10);
        end else begin
          rcv_hold--;
        end
        m_axis_tready_i <= rcv_level;
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (deframed_q.size() == 0) begin
        $error("result with nothing expected: tdata=%h tuser=%h tlast=%b",
               m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        mismatch_count++;
      end else begin
        want = deframed_q.pop_front();
        if (m_axis_tuser_o[1:0] !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser_o[1:0]);
          mismatch_count++;
        end
        if (m_axis_tdata_o[7:0] !== want.data) begin
          $error("payload_data: expected %h, got %h", want.data, m_axis_tdata_o[7:0]);
          mismatch_count++;
        end
        if (m_axis_tdata_o[11:8] !== want.opcode) begin
          $error("frame_opcode: expected %h, got %h", want.opcode, m_axis_tdata_o[11:8]);
          mismatch_count++;
        end
        if (m_axis_tuser_o[2] !== want.done) begin
          $error("payload_done: expected %b, got %b", want.done, m_axis_tuser_o[2]);
          mismatch_count++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("run_last: expected %b, got %b", want.last, m_axis_tlast_o);
          mismatch_count++;
        end
      end
    end
  end

  // Ends a hung run: counts cycles in which neither side completes a transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule
